@@ rtl/core/gbc_pkg.sv @@
// Shared types and constants of the gyro bias calibration block.
`default_nettype none
package gbc_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned RATE_BITS   = 16;
  localparam int unsigned CFG_BITS    = 13;

  localparam logic CFG_CAL_CYCLES = 1'b0;
  localparam logic CFG_MOTION_THR = 1'b1;

  localparam logic [CFG_BITS-1:0] CAL_CYCLES_RST = 13'd1000;
  localparam logic [CFG_BITS-1:0] MOTION_THR_RST = 13'd32;

  localparam logic [1:0] LAST_AXIS = 2'd2;

  typedef struct packed {
    logic                          start_calibration;
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic signed [SAMPLE_BITS-1:0] sample_z;
  } gbc_in_t;

  typedef struct packed {
    logic signed [RATE_BITS-1:0] rate_x;
    logic signed [RATE_BITS-1:0] rate_y;
    logic signed [RATE_BITS-1:0] rate_z;
    logic                        calibrating;
    logic                        cal_accepted;
    logic                        cal_rejected;
  } gbc_out_t;

  typedef enum logic [2:0] {
    MOP_TSQ = 3'd0,
    MOP_C1  = 3'd1,
    MOP_C2  = 3'd2,
    MOP_A   = 3'd3,
    MOP_B   = 3'd4
  } gbc_mop_e;

  typedef struct packed {
    logic       accept;
    logic       mul_load;
    logic       mul_step;
    gbc_mop_e   mul_op;
    logic       store_c;
    logic       cmp;
    logic       div_load;
    logic       div_step;
    logic       div_store;
    logic [1:0] axis;
    logic       finish;
    logic       reject;
  } gbc_cmd_t;

  typedef struct packed {
    logic finishing;
    logic check_en;
    logic moving;
  } gbc_status_t;

endpackage
`default_nettype wire

@@ rtl/core/gbc_dp.sv @@
// Datapath of the gyro bias calibration block: sums, offsets, multiplier and divider.
`default_nettype none
module gbc_dp #(
  parameter int unsigned MAX_CAL_CYCLES = 4096
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire gbc_pkg::gbc_in_t          in_i,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_idx_i,
  input  wire logic [gbc_pkg::CFG_BITS-1:0] cfg_data_i,
  input  wire gbc_pkg::gbc_cmd_t         cmd_i,
  output gbc_pkg::gbc_status_t           status_o,
  output gbc_pkg::gbc_out_t              out_o
);
  import gbc_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_CAL_CYCLES + 1);
  localparam int unsigned SUM_W = SAMPLE_BITS + CW;
  localparam int unsigned SQ_W  = 2 * SAMPLE_BITS + CW;
  localparam int unsigned PW    = 2 * SUM_W + 1;
  localparam int unsigned DW    = SUM_W + 1;

  function automatic logic signed [RATE_BITS-1:0] sat_rate(logic signed [RATE_BITS:0] v);
    logic signed [RATE_BITS-1:0] r;
    if (v[RATE_BITS] != v[RATE_BITS-1]) begin
      r = v[RATE_BITS] ? {1'b1, {(RATE_BITS-1){1'b0}}} : {1'b0, {(RATE_BITS-1){1'b1}}};
    end else begin
      r = v[RATE_BITS-1:0];
    end
    return r;
  endfunction

  logic [CFG_BITS-1:0]          cal_cycles_q, thr_q;
  logic [CW-1:0]                cycles_left_q, run_len_q;
  logic signed [SUM_W-1:0]      sum_q [3];
  logic [SQ_W-1:0]              sq_q [3];
  logic signed [RATE_BITS-1:0]  off_q [3];
  logic                         moving_q;
  logic [PW-1:0]                acc_q, mcand_q, a_q, c_q;
  logic [SUM_W-1:0]             mplier_q;
  logic [CW:0]                  rem_q;
  logic [DW-1:0]                dq_q;
  logic                         neg_q;
  gbc_out_t                     out_q;

  logic signed [SAMPLE_BITS-1:0] smp [3];
  logic [CW-1:0]                 n_start, cl_eff;
  logic signed [SUM_W-1:0]       sum_nx [3];
  logic [SQ_W-1:0]               sq_nx [3];
  logic signed [2*SAMPLE_BITS-1:0] prod [3];
  logic signed [RATE_BITS-1:0]   rate [3];
  logic signed [SUM_W-1:0]       sum_sel;
  logic [SUM_W-1:0]              mag_sel;
  logic [PW-1:0]                 mul_a;
  logic [SUM_W-1:0]              mul_b;
  logic [PW:0]                   rhs;
  logic                          gt;
  logic signed [DW-1:0]          dvd;
  logic [CW:0]                   r2;
  logic                          ge;
  logic [DW-1:0]                 quo;
  logic                          in_cal;

  assign smp[0] = in_i.sample_x;
  assign smp[1] = in_i.sample_y;
  assign smp[2] = in_i.sample_z;

  always_comb begin
    if (cal_cycles_q < CFG_BITS'(2)) begin
      n_start = CW'(2);
    end else if (32'(cal_cycles_q) > 32'(MAX_CAL_CYCLES)) begin
      n_start = CW'(MAX_CAL_CYCLES);
    end else begin
      n_start = CW'(cal_cycles_q);
    end
    cl_eff = in_i.start_calibration ? n_start : cycles_left_q;
  end

  assign in_cal = (cl_eff != '0);

  for (genvar k = 0; k < 3; k++) begin : g_lane
    assign prod[k]   = smp[k] * smp[k];
    assign sum_nx[k] = (in_i.start_calibration ? '0 : sum_q[k]) + SUM_W'(smp[k]);
    assign sq_nx[k]  = (in_i.start_calibration ? '0 : sq_q[k])
                       + SQ_W'($unsigned(prod[k]));
    assign rate[k]   = sat_rate((RATE_BITS+1)'(smp[k]) - (RATE_BITS+1)'(off_q[k]));
  end

  assign sum_sel = sum_q[cmd_i.axis];
  assign mag_sel = sum_sel[SUM_W-1] ? $unsigned(-sum_sel) : $unsigned(sum_sel);

  always_comb begin
    case (cmd_i.mul_op)
      MOP_TSQ: begin
        mul_a = PW'(thr_q);
        mul_b = SUM_W'(thr_q);
      end
      MOP_C1: begin
        mul_a = acc_q;
        mul_b = SUM_W'(run_len_q);
      end
      MOP_C2: begin
        mul_a = acc_q;
        mul_b = SUM_W'(run_len_q - CW'(1));
      end
      MOP_A: begin
        mul_a = PW'(sq_q[cmd_i.axis]);
        mul_b = SUM_W'(run_len_q);
      end
      MOP_B: begin
        mul_a = PW'(mag_sel);
        mul_b = mag_sel;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign rhs = (PW+1)'(acc_q) + (PW+1)'(c_q);
  assign gt  = {1'b0, a_q} > rhs;

  assign dvd = DW'(sum_sel) + DW'(run_len_q >> 1);
  assign r2  = {rem_q[CW-1:0], dq_q[DW-1]};
  assign ge  = r2 >= {1'b0, run_len_q};
  assign quo = neg_q ? -dq_q : dq_q;

  assign status_o.finishing = in_cal && (cl_eff == CW'(1));
  assign status_o.check_en  = (thr_q != '0);
  assign status_o.moving    = moving_q | gt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_cycles_q  <= CAL_CYCLES_RST;
      thr_q         <= MOTION_THR_RST;
      cycles_left_q <= '0;
      run_len_q     <= '0;
      moving_q      <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= '0;
        sq_q[k]  <= '0;
        off_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_CAL_CYCLES) begin
          cal_cycles_q <= cfg_data_i;
        end else if (cfg_idx_i == CFG_MOTION_THR) begin
          thr_q <= cfg_data_i;
        end
      end
      if (cmd_i.accept && in_cal) begin
        if (in_i.start_calibration) begin
          run_len_q <= n_start;
        end
        cycles_left_q <= cl_eff - CW'(1);
        moving_q      <= 1'b0;
        for (int k = 0; k < 3; k++) begin
          sum_q[k] <= sum_nx[k];
          sq_q[k]  <= sq_nx[k];
          off_q[k] <= '0;
        end
      end
      if (cmd_i.cmp && gt) begin
        moving_q <= 1'b1;
      end
      if (cmd_i.div_store) begin
        off_q[cmd_i.axis] <= RATE_BITS'(quo);
      end
      if (cmd_i.finish && cmd_i.reject) begin
        cycles_left_q <= run_len_q;
        for (int k = 0; k < 3; k++) begin
          sum_q[k] <= '0;
          sq_q[k]  <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      acc_q    <= '0;
      mcand_q  <= mul_a;
      mplier_q <= mul_b;
      if (cmd_i.mul_op == MOP_B) begin
        a_q <= acc_q;
      end
      if (cmd_i.store_c) begin
        c_q <= acc_q;
      end
    end else if (cmd_i.mul_step) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end
    if (cmd_i.div_load) begin
      rem_q <= '0;
      neg_q <= dvd[DW-1];
      dq_q  <= dvd[DW-1] ? $unsigned(-dvd) : $unsigned(dvd);
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? r2 - {1'b0, run_len_q} : r2;
      dq_q  <= {dq_q[DW-2:0], ge};
    end
    if (cmd_i.accept && !status_o.finishing) begin
      if (in_cal) begin
        out_q <= '{rate_x: '0, rate_y: '0, rate_z: '0, calibrating: 1'b1,
                   cal_accepted: 1'b0, cal_rejected: 1'b0};
      end else begin
        out_q <= '{rate_x: rate[0], rate_y: rate[1], rate_z: rate[2],
                   calibrating: 1'b0, cal_accepted: 1'b0, cal_rejected: 1'b0};
      end
    end else if (cmd_i.finish) begin
      out_q <= '{rate_x: '0, rate_y: '0, rate_z: '0, calibrating: 1'b1,
                 cal_accepted: !cmd_i.reject, cal_rejected: cmd_i.reject};
    end
  end

  assign out_o = out_q;

endmodule
`default_nettype wire

@@ rtl/core/gbc_ctrl.sv @@
// Controller of the gyro bias calibration block: handshakes and the end-of-run sequence.
`default_nettype none
module gbc_ctrl #(
  parameter int unsigned MAX_CAL_CYCLES = 4096
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire gbc_pkg::gbc_status_t status_i,
  output gbc_pkg::gbc_cmd_t         cmd_o
);
  import gbc_pkg::*;

  localparam int unsigned CW        = $clog2(MAX_CAL_CYCLES + 1);
  localparam int unsigned MUL_STEPS = SAMPLE_BITS + CW;
  localparam int unsigned DIV_STEPS = MUL_STEPS + 1;
  localparam int unsigned IW        = $clog2(DIV_STEPS);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MLOAD  = 8'b0000_0010,
    S_MRUN   = 8'b0000_0100,
    S_CMP    = 8'b0000_1000,
    S_DLOAD  = 8'b0001_0000,
    S_DRUN   = 8'b0010_0000,
    S_DSTORE = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } gbc_state_e;

  gbc_state_e state_q, state_d;
  gbc_mop_e   mop_q, mop_d;
  logic [1:0] axis_q, axis_d;
  logic [IW-1:0] iter_q, iter_d;
  logic       reject_q, reject_d;
  logic       out_valid_q, out_valid_d;
  logic       accept, load_out;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d  = state_q;
    mop_d    = mop_q;
    axis_d   = axis_q;
    iter_d   = iter_q;
    reject_d = reject_q;
    load_out = 1'b0;
    cmd_o          = '0;
    cmd_o.mul_op   = mop_q;
    cmd_o.axis     = axis_q;
    cmd_o.reject   = reject_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          if (status_i.finishing) begin
            axis_d   = '0;
            reject_d = 1'b0;
            if (status_i.check_en) begin
              mop_d   = MOP_TSQ;
              state_d = S_MLOAD;
            end else begin
              state_d = S_DLOAD;
            end
          end else begin
            load_out = 1'b1;
          end
        end
      end
      S_MLOAD: begin
        cmd_o.mul_load = 1'b1;
        cmd_o.store_c  = (mop_q == MOP_A) && (axis_q == '0);
        iter_d         = '0;
        state_d        = S_MRUN;
      end
      S_MRUN: begin
        cmd_o.mul_step = 1'b1;
        iter_d         = iter_q + IW'(1);
        if (iter_q == IW'(MUL_STEPS - 1)) begin
          state_d = S_MLOAD;
          case (mop_q)
            MOP_TSQ: mop_d = MOP_C1;
            MOP_C1:  mop_d = MOP_C2;
            MOP_C2:  mop_d = MOP_A;
            MOP_A:   mop_d = MOP_B;
            default: state_d = S_CMP;
          endcase
        end
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        if (axis_q == LAST_AXIS) begin
          axis_d = '0;
          if (status_i.moving) begin
            reject_d = 1'b1;
            state_d  = S_FINISH;
          end else begin
            state_d = S_DLOAD;
          end
        end else begin
          axis_d  = axis_q + 2'd1;
          mop_d   = MOP_A;
          state_d = S_MLOAD;
        end
      end
      S_DLOAD: begin
        cmd_o.div_load = 1'b1;
        iter_d         = '0;
        state_d        = S_DRUN;
      end
      S_DRUN: begin
        cmd_o.div_step = 1'b1;
        iter_d         = iter_q + IW'(1);
        if (iter_q == IW'(DIV_STEPS - 1)) begin
          state_d = S_DSTORE;
        end
      end
      S_DSTORE: begin
        cmd_o.div_store = 1'b1;
        if (axis_q == LAST_AXIS) begin
          state_d = S_FINISH;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = S_DLOAD;
        end
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        load_out     = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = (out_valid_q && !out_ready_i) || load_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mop_q       <= MOP_TSQ;
      axis_q      <= '0;
      iter_q      <= '0;
      reject_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mop_q       <= mop_d;
      axis_q      <= axis_d;
      iter_q      <= iter_d;
      reject_q    <= reject_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/gyro_bias_calibration_motion_check_core.sv @@
// Top level of the gyro bias calibration block with motion check.
// An ordinary request's result is registered, and one request per cycle is taken while the
// result is collected. The request that ends a calibration run starts the end-of-run
// sequence in a shared shift-and-add multiplier and a restoring divider, one bit per
// cycle; with the motion check disabled only the divider runs. A run rejected by the
// motion check skips the divider. No request is taken until the sequence ends.
`default_nettype none
module gyro_bias_calibration_motion_check_core #(
  parameter int unsigned MAX_CAL_CYCLES = 4096
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire gbc_pkg::gbc_in_t             in_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output gbc_pkg::gbc_out_t                 out_o,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_idx_i,
  input  wire logic [gbc_pkg::CFG_BITS-1:0] cfg_data_i
);
  import gbc_pkg::*;

  gbc_cmd_t    cmd;
  gbc_status_t status;

  gbc_ctrl #(
    .MAX_CAL_CYCLES(MAX_CAL_CYCLES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gbc_dp #(
    .MAX_CAL_CYCLES(MAX_CAL_CYCLES)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cmd_i     (cmd),
    .status_o  (status),
    .out_o     (out_o)
  );

endmodule
`default_nettype wire

@@ bench/tb_gyro_bias_calibration_motion_check_core.sv @@
// Testbench for the gyro bias calibration core with motion check.
`timescale 1ns / 1ps
module tb_gyro_bias_calibration_motion_check_core;
  import gbc_pkg::*;

  localparam int unsigned MAX_RUN = 4096;
  localparam int unsigned DRAIN_CYCLES = 450;
  localparam longint unsigned CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  gbc_in_t in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  gbc_out_t out_o;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = CFG_CAL_CYCLES;
  logic [CFG_BITS-1:0] cfg_data_i = '0;

  gyro_bias_calibration_motion_check_core dut (
    .clk_i(clk), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_i(in_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_o(out_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk = ~clk;

  logic [CFG_BITS-1:0] run_cycles_cfg = CAL_CYCLES_RST;
  logic [CFG_BITS-1:0] motion_thr_cfg = MOTION_THR_RST;
  int unsigned samples_left = 0;
  int unsigned latched_len = 0;
  longint axis_sum[3];
  longint unsigned axis_sq[3];
  int axis_off[3];

  gbc_out_t exp_rates[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  bit idle_en = 1'b1;
  int hold_req = 0;
  int hold_done = 0;
  int unsigned hold_cycles = 0;
  int unsigned out_stall = 0;
  longint unsigned cycle_count = 0;

  function automatic logic [15:0] sat16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic bit axis_moving(int k, longint unsigned n, longint unsigned thr);
    logic [127:0] lhs;
    logic [127:0] rhs;
    logic [127:0] mag;
    mag = (axis_sum[k] < 0) ? 128'(-axis_sum[k]) : 128'(axis_sum[k]);
    lhs = 128'(n) * 128'(axis_sq[k]);
    rhs = mag * mag + 128'(thr) * 128'(thr) * 128'(n) * 128'(n - 1);
    return lhs > rhs;
  endfunction

  function automatic gbc_out_t predict_rate(gbc_in_t r);
    gbc_out_t o;
    longint s[3];
    int unsigned n;
    bit moving;
    o = '0;
    s[0] = longint'($signed(r.sample_x));
    s[1] = longint'($signed(r.sample_y));
    s[2] = longint'($signed(r.sample_z));
    if (r.start_calibration) begin
      n = run_cycles_cfg;
      if (n < 2) n = 2;
      if (n > MAX_RUN) n = MAX_RUN;
      latched_len = n;
      samples_left = n;
      for (int k = 0; k < 3; k++) begin
        axis_sum[k] = 0;
        axis_sq[k] = 0;
      end
    end
    if (samples_left == 0) begin
      o.rate_x = sat16(s[0] - axis_off[0]);
      o.rate_y = sat16(s[1] - axis_off[1]);
      o.rate_z = sat16(s[2] - axis_off[2]);
      return o;
    end
    for (int k = 0; k < 3; k++) begin
      axis_sum[k] += s[k];
      axis_sq[k] += longint'(s[k] * s[k]);
      axis_off[k] = 0;
    end
    samples_left--;
    o.calibrating = 1'b1;
    if (samples_left == 0) begin
      moving = 1'b0;
      if (motion_thr_cfg != 0)
        for (int k = 0; k < 3; k++)
          if (axis_moving(k, latched_len, motion_thr_cfg)) moving = 1'b1;
      if (moving) begin
        for (int k = 0; k < 3; k++) begin
          axis_sum[k] = 0;
          axis_sq[k] = 0;
        end
        samples_left = latched_len;
        o.cal_rejected = 1'b1;
      end else begin
        for (int k = 0; k < 3; k++)
          axis_off[k] = int'((axis_sum[k] + longint'(latched_len / 2)) / longint'(latched_len));
        o.cal_accepted = 1'b1;
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("mismatch in %s: got %0d, expected %0d", what, got, want);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (exp_rates.size() == 0) begin
        report_mismatch("unexpected result count", 1, 0);
      end else begin
        gbc_out_t e;
        e = exp_rates.pop_front();
        if (out_o.rate_x !== e.rate_x) report_mismatch("rate_x", out_o.rate_x, e.rate_x);
        if (out_o.rate_y !== e.rate_y) report_mismatch("rate_y", out_o.rate_y, e.rate_y);
        if (out_o.rate_z !== e.rate_z) report_mismatch("rate_z", out_o.rate_z, e.rate_z);
        if (out_o.calibrating !== e.calibrating)
          report_mismatch("calibrating", out_o.calibrating, e.calibrating);
        if (out_o.cal_accepted !== e.cal_accepted)
          report_mismatch("cal_accepted", out_o.cal_accepted, e.cal_accepted);
        if (out_o.cal_rejected !== e.cal_rejected)
          report_mismatch("cal_rejected", out_o.cal_rejected, e.cal_rejected);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_done != hold_req) begin
      hold_done <= hold_req;
      hold_cycles <= 600;
      out_ready_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (idle_en && $urandom_range(0, 9) == 0) out_stall <= $urandom_range(1, 14);
    end
  end

  task automatic send_request(bit start, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    int unsigned gap;
    gbc_in_t r;
    gap = (idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    r.start_calibration = start;
    r.sample_x = x;
    r.sample_y = y;
    r.sample_z = z;
    in_valid_i <= 1'b1;
    in_i <= r;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    exp_rates.push_back(predict_rate(r));
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk);
    while (exp_rates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_BITS-1:0] value);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    if (idx == CFG_CAL_CYCLES) run_cycles_cfg = value;
    else motion_thr_cfg = value;
    @(posedge clk);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] noisy(int bias, int amp);
    int v;
    v = bias + ((amp == 0) ? 0 : $urandom_range(0, 2 * amp) - amp);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic send_run(int unsigned len, int bias, int amp);
    for (int unsigned i = 0; i < len; i++)
      send_request(i == 0, noisy(bias, amp), noisy(-bias, amp), noisy(bias / 3, amp));
  endtask

  task automatic test_passthrough();
    send_request(1'b0, 16'sh7fff, 16'sh8000, 16'h0000);
    send_request(1'b0, 16'hffff, 16'h0001, 16'sh8000);
    send_request(1'b0, 16'h5555, 16'haaaa, 16'h7fff);
  endtask

  task automatic test_saturation();
    write_reg(CFG_CAL_CYCLES, 13'd0);
    write_reg(CFG_MOTION_THR, 13'd0);
    send_run(2, 32767, 0);
    send_request(1'b0, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_request(1'b0, 16'sh7fff, 16'h0000, 16'h0000);
    send_request(1'b1, 16'sh8000, 16'sh8000, 16'sh8000);
    send_request(1'b0, 16'sh8000, 16'sh8000, 16'sh8000);
    send_request(1'b0, 16'sh7fff, 16'sh8000, 16'sh7fff);
    write_reg(CFG_CAL_CYCLES, 13'd1);
    send_run(2, 3, 0);
    send_request(1'b0, 16'd7, 16'd0, 16'd1);
  endtask

  task automatic test_motion_check();
    write_reg(CFG_CAL_CYCLES, 13'd4);
    write_reg(CFG_MOTION_THR, 13'd1);
    send_request(1'b1, 16'd0, 16'd0, 16'd0);
    send_request(1'b0, 16'd100, 16'd0, 16'd0);
    send_request(1'b0, 16'd0, 16'd0, 16'd0);
    send_request(1'b1, 16'd0, 16'd0, 16'd0);
    for (int i = 0; i < 3; i++) send_request(1'b0, 16'd0, 16'd0, 16'd900);
    write_reg(CFG_CAL_CYCLES, 13'd6);
    for (int i = 0; i < 4; i++) send_request(1'b0, 16'd5, 16'd5, 16'd5);
    send_request(1'b0, 16'd10, 16'd10, 16'd10);
    send_request(1'b0, 16'd11, 16'd10, 16'd10);
  endtask

  task automatic test_random_runs();
    int amp;
    int bias;
    while (items_sent < 980) begin
      case ($urandom_range(0, 5))
        0: write_reg(CFG_CAL_CYCLES, 13'($urandom_range(0, 3)));
        1, 2: write_reg(CFG_CAL_CYCLES, 13'($urandom_range(2, 24)));
        3: write_reg(CFG_MOTION_THR, 13'($urandom_range(0, 1) ? 0 : 8191));
        default: write_reg(CFG_MOTION_THR, 13'($urandom_range(1, 200)));
      endcase
      repeat ($urandom_range(2, 6)) begin
        bias = int'($urandom_range(0, 65535)) - 32768;
        if ($urandom_range(0, 2) != 0) bias = bias / 64;
        case ($urandom_range(0, 3))
          0: amp = 0;
          1: amp = $urandom_range(1, 8);
          2: amp = $urandom_range(16, 400);
          default: amp = $urandom_range(1000, 30000);
        endcase
        send_run($urandom_range(0, 5) == 0 ? $urandom_range(1, 4) : run_cycles_cfg + 1,
                 bias, amp);
        repeat ($urandom_range(0, 6))
          send_request($urandom_range(0, 15) == 0, 16'($urandom), 16'($urandom),
                       16'($urandom));
      end
    end
  endtask

  task automatic test_backpressure();
    write_reg(CFG_CAL_CYCLES, 13'd3);
    write_reg(CFG_MOTION_THR, 13'd0);
    @(posedge clk);
    hold_req++;
    for (int i = 0; i < 40; i++)
      send_request(i % 10 == 0, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic test_longest_run();
    idle_en = 1'b0;
    write_reg(CFG_CAL_CYCLES, 13'd500);
    write_reg(CFG_MOTION_THR, 13'd8191);
    send_run(500, -12345, 3000);
    for (int i = 0; i < 20; i++)
      send_request(1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_passthrough();
    test_saturation();
    test_motion_check();
    test_random_runs();
    test_backpressure();
    test_longest_run();
    wait_idle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
